### sv/fgsa_pkg.sv
package fgsa_pkg;

	// field and register widths
	localparam int CFG_W  = 9;
	localparam int SEAT_W = 8;
	localparam int STAT_W = 2;

	// default row capacity and seat count after reset
	localparam int MAX_SEATS_DEF = 256;
	localparam logic [CFG_W-1:0] SEAT_COUNT_RST = 9'd256;

	// request codes
	localparam logic MODE_OCCUPY  = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] ST_SEATED   = 2'd0;
	localparam logic [STAT_W-1:0] ST_RELEASED = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_OCC  = 2'd3;

	// sequencer states
	typedef enum logic [2:0] {
		CLEARING,
		IDLE,
		REL_READ,
		REL_CHECK,
		SCANNING,
		DRAINING,
		COMMIT
	} state_t;

	// scan control from the sequencer to the run tracker
	typedef struct packed {
		logic clear;
		logic bit_vld;
		logic bit_last;
	} scan_ctl_t;

	// closed free run from the run tracker to the gap unit
	typedef struct packed {
		logic vld;
		logic at_right;
	} run_ctl_t;

endpackage

### sv/fgsa_map_ram.sv
module fgsa_map_ram import fgsa_pkg::*; #(
	parameter int MAX_SEATS = MAX_SEATS_DEF,
	localparam int AW = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic          wr_bit,
	input  logic [AW-1:0] rd_addr,
	output logic          rd_bit
);

	logic mem [MAX_SEATS];

	// one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_bit;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_bit <= mem[rd_addr];
	end

endmodule

### sv/fgsa_run_tracker.sv
module fgsa_run_tracker import fgsa_pkg::*; #(
	parameter int MAX_SEATS = MAX_SEATS_DEF,
	localparam int AW = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  scan_ctl_t     ctl,
	input  logic          bit_occ,
	input  logic [AW-1:0] bit_idx,
	output run_ctl_t      run_s2,
	output logic [AW-1:0] run_l_s2,
	output logic [AW-1:0] run_r_s2
);

	logic          in_run_q;
	logic [AW-1:0] run_start_q;
	logic          in_run_d;
	logic [AW-1:0] run_start_d;
	run_ctl_t      run_d;
	logic [AW-1:0] l_d;
	logic [AW-1:0] r_d;

	// follow free runs over the slot stream and close them
	always_comb begin
		in_run_d       = in_run_q;
		run_start_d    = run_start_q;
		run_d.vld      = 1'b0;
		run_d.at_right = 1'b0;
		l_d            = run_start_q;
		r_d            = bit_idx;
		if (ctl.clear) begin
			in_run_d = 1'b0;
		end else if (ctl.bit_vld) begin
			if (!bit_occ) begin
				if (!in_run_q) begin
					run_start_d = bit_idx;
					l_d         = bit_idx;
				end
				in_run_d = !ctl.bit_last;
				if (ctl.bit_last) begin
					run_d.vld      = 1'b1;
					run_d.at_right = 1'b1;
					r_d            = bit_idx;
				end
			end else if (in_run_q) begin
				run_d.vld = 1'b1;
				r_d       = bit_idx - AW'(1);
				in_run_d  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q <= 1'b0;
			run_s2   <= '0;
		end else begin
			in_run_q <= in_run_d;
			run_s2   <= run_d;
		end
	end

	// run bounds, payload only
	always_ff @(posedge clk) begin
		run_start_q <= run_start_d;
		run_l_s2    <= l_d;
		run_r_s2    <= r_d;
	end

endmodule

### sv/fgsa_gap_eval.sv
module fgsa_gap_eval import fgsa_pkg::*; #(
	parameter int MAX_SEATS = MAX_SEATS_DEF,
	localparam int AW = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1,
	localparam int CW = $clog2(MAX_SEATS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  run_ctl_t      run,
	input  logic [AW-1:0] run_l,
	input  logic [AW-1:0] run_r,
	output logic          best_vld,
	output logic [AW-1:0] best_seat
);

	logic          best_vld_q;
	logic [CW-1:0] best_dist_q;
	logic [AW-1:0] best_seat_q;
	logic [AW-1:0] span;
	logic [AW:0]   sum;
	logic [CW-1:0] gap_dist;
	logic [AW-1:0] seat;
	logic          take;

	// distance and seat of one closed run
	always_comb begin
		span = run_r - run_l;
		sum  = {1'b0, run_l} + {1'b0, run_r};
		if (run_l == '0) begin
			gap_dist = CW'(run_r) + CW'(1);
			seat     = '0;
		end else if (run.at_right) begin
			gap_dist = CW'(span) + CW'(1);
			seat     = run_r;
		end else begin
			gap_dist = CW'(span >> 1) + CW'(1);
			seat     = sum[AW:1];
		end
		take = run.vld && (!best_vld_q || (gap_dist > best_dist_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q <= 1'b0;
		end else if (clear) begin
			best_vld_q <= 1'b0;
		end else if (take) begin
			best_vld_q <= 1'b1;
		end
	end

	// strict compare keeps the lowest seat on a tie
	always_ff @(posedge clk) begin
		if (take) begin
			best_dist_q <= gap_dist;
			best_seat_q <= seat;
		end
	end

	assign best_vld  = best_vld_q;
	assign best_seat = best_seat_q;

endmodule

### sv/farthest_gap_slot_allocator.sv
// channel   direction  signals                         handshake
// request   in         mode, seat_index                start high while busy low
// result    out        chosen_seat, status             done strobe, one cycle
// config    in         seat_count                      cfg_valid and cfg_ready
//
// an occupy scans the map one slot per cycle through the map ram read port;
// busy through the scan of the n slots in use, a drain of the run tracker, and a commit
// a release reads and writes back one slot, in a read state and a check state
// after reset a clearing pass writes every slot free, busy high
// the result beat is in the first cycle with busy low; the receiver cannot stall it
// seat count writes wait while busy
module farthest_gap_slot_allocator import fgsa_pkg::*; #(
	parameter int MAX_SEATS = MAX_SEATS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              mode,
	input  logic [SEAT_W-1:0] seat_index,
	output logic              done,
	output logic [SEAT_W-1:0] chosen_seat,
	output logic [STAT_W-1:0] status,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  seat_count
);

	localparam int AW   = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
	localparam int CW   = $clog2(MAX_SEATS + 1);
	localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

	state_t            state_q;
	state_t            state_d;
	logic [CFG_W-1:0]  seat_count_q;
	logic [AW-1:0]     addr_q;
	logic [SEAT_W-1:0] idx_q;
	logic              done_q;
	logic [SEAT_W-1:0] chosen_q;
	logic [STAT_W-1:0] status_q;
	logic              bit_vld_s1;
	logic              bit_last_s1;
	logic [AW-1:0]     bit_idx_s1;

	logic [CMPW-1:0]   cnt_ext;
	logic [CMPW-1:0]   n_eff;
	logic [CMPW-1:0]   idx_ext;
	logic [CMPW-1:0]   best_ext;
	logic              idx_in_row;
	logic              scan_last;
	logic              accept;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic              mem_wbit;
	logic [AW-1:0]     mem_raddr;
	logic              rd_bit;
	logic              scan_issue;
	logic              done_d;
	logic [SEAT_W-1:0] chosen_d;
	logic [STAT_W-1:0] status_d;

	scan_ctl_t         scan_ctl;
	run_ctl_t          run_s2;
	logic [AW-1:0]     run_l_s2;
	logic [AW-1:0]     run_r_s2;
	logic              best_vld;
	logic [AW-1:0]     best_seat;

	// effective row length and request range check
	always_comb begin
		cnt_ext = CMPW'(seat_count_q);
		if (cnt_ext == '0) begin
			n_eff = CMPW'(1);
		end else if (cnt_ext > CMPW'(MAX_SEATS)) begin
			n_eff = CMPW'(MAX_SEATS);
		end else begin
			n_eff = cnt_ext;
		end
		idx_ext    = CMPW'(idx_q);
		idx_in_row = idx_ext < n_eff;
		scan_last  = CMPW'(addr_q) == (n_eff - CMPW'(1));
		best_ext   = CMPW'(best_seat);
	end

	assign accept    = start && (state_q == IDLE);
	assign busy      = state_q != IDLE;
	assign cfg_ready = !busy;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CLEARING: begin
				if (addr_q == AW'(MAX_SEATS - 1)) state_d = IDLE;
			end
			IDLE: begin
				if (start) state_d = (mode == MODE_RELEASE) ? REL_READ : SCANNING;
			end
			REL_READ:  state_d = REL_CHECK;
			REL_CHECK: state_d = IDLE;
			SCANNING: begin
				if (scan_last) state_d = DRAINING;
			end
			DRAINING: begin
				if (!bit_vld_s1 && !run_s2.vld) state_d = COMMIT;
			end
			COMMIT:    state_d = IDLE;
			default:   state_d = IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = addr_q;
		mem_wbit   = 1'b0;
		mem_raddr  = addr_q;
		scan_issue = 1'b0;
		done_d     = 1'b0;
		chosen_d   = idx_q;
		status_d   = ST_NOT_OCC;
		case (state_q)
			CLEARING: begin
				mem_we = 1'b1;
			end
			REL_READ: begin
				mem_raddr = idx_ext[AW-1:0];
			end
			REL_CHECK: begin
				mem_waddr = idx_ext[AW-1:0];
				done_d    = 1'b1;
				if (idx_in_row && rd_bit) begin
					mem_we   = 1'b1;
					status_d = ST_RELEASED;
				end
			end
			SCANNING: begin
				scan_issue = 1'b1;
			end
			COMMIT: begin
				done_d    = 1'b1;
				mem_waddr = best_seat;
				mem_wbit  = 1'b1;
				if (best_vld) begin
					mem_we   = 1'b1;
					chosen_d = best_ext[SEAT_W-1:0];
					status_d = ST_SEATED;
				end else begin
					chosen_d = '0;
					status_d = ST_FULL;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= CLEARING;
			seat_count_q <= SEAT_COUNT_RST;
			addr_q       <= '0;
			done_q       <= 1'b0;
			bit_vld_s1   <= 1'b0;
		end else begin
			state_q    <= state_d;
			done_q     <= done_d;
			bit_vld_s1 <= scan_issue;
			if (cfg_valid && cfg_ready) begin
				seat_count_q <= seat_count;
			end
			if (accept) begin
				addr_q <= '0;
			end else if (state_q inside {CLEARING, SCANNING}) begin
				addr_q <= addr_q + AW'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= seat_index;
		end
		chosen_q    <= chosen_d;
		status_q    <= status_d;
		bit_last_s1 <= scan_last;
		bit_idx_s1  <= addr_q;
	end

	assign done        = done_q;
	assign chosen_seat = chosen_q;
	assign status      = status_q;

	// occupancy map
	fgsa_map_ram #(
		.MAX_SEATS(MAX_SEATS)
	) u_map (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_bit (mem_wbit),
		.rd_addr(mem_raddr),
		.rd_bit (rd_bit)
	);

	// free run tracking over the scanned slots
	always_comb begin
		scan_ctl.clear    = accept;
		scan_ctl.bit_vld  = bit_vld_s1;
		scan_ctl.bit_last = bit_last_s1;
	end

	fgsa_run_tracker #(
		.MAX_SEATS(MAX_SEATS)
	) u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (scan_ctl),
		.bit_occ (rd_bit),
		.bit_idx (bit_idx_s1),
		.run_s2  (run_s2),
		.run_l_s2(run_l_s2),
		.run_r_s2(run_r_s2)
	);

	// gap distance and best seat unit
	fgsa_gap_eval #(
		.MAX_SEATS(MAX_SEATS)
	) u_gap (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (accept),
		.run      (run_s2),
		.run_l    (run_l_s2),
		.run_r    (run_r_s2),
		.best_vld (best_vld),
		.best_seat(best_seat)
	);

`ifndef SYNTH
	// a result beat only follows a release check or a commit
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == REL_CHECK || $past(state_q) == COMMIT))
		else $error("result beat without a finished request");

	// an accepted request keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// a full room never names a seat
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (chosen_seat == '0))
		else $error("room full with nonzero seat");

	// closed runs only appear while a scan is in flight
	a_run_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		run_s2.vld |-> (state_q == SCANNING || state_q == DRAINING))
		else $error("run closed outside a scan");
`endif

endmodule

### tb/fgsa_result_checker.sv
module fgsa_result_checker import fgsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              mode,
	input  logic [SEAT_W-1:0] seat_index,
	input  logic              done,
	input  logic [SEAT_W-1:0] chosen_seat,
	input  logic [STAT_W-1:0] status,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CFG_W-1:0]  seat_count,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [SEAT_W-1:0] seat;
		logic [STAT_W-1:0] stat;
	} seat_result_t;

	// shadow of the occupancy map and the seat count register
	logic             seat_taken [MAX_SEATS_DEF];
	logic [CFG_W-1:0] row_setting;
	seat_result_t     results_due [$];
	int               mismatches = 0;

	// predict one request and update the shadow map
	function automatic seat_result_t predict_seat(input logic m, input logic [SEAT_W-1:0] idx);
		seat_result_t res;
		int n, i, l, r, d, s, best_d, best_s;
		bit found;
		n = int'(row_setting);
		if (n == 0) n = 1;
		if (n > MAX_SEATS_DEF) n = MAX_SEATS_DEF;
		found = 1'b0;
		best_d = 0;
		best_s = 0;
		res.seat = idx;
		// release frees an occupied slot inside the row, anything else is refused
		if (m == MODE_RELEASE) begin
			if (idx < n && seat_taken[idx]) begin
				seat_taken[idx] = 1'b0;
				res.stat = ST_RELEASED;
			end else begin
				res.stat = ST_NOT_OCC;
			end
			return res;
		end
		// walk free runs, keep the first widest one
		i = 0;
		while (i < n) begin
			if (seat_taken[i]) begin
				i++;
				continue;
			end
			l = i;
			while (i + 1 < n && !seat_taken[i + 1]) i++;
			r = i;
			if (l == 0) begin
				d = r + 1;
				s = 0;
			end else if (r == n - 1) begin
				d = r - l + 1;
				s = r;
			end else begin
				d = (r - l) / 2 + 1;
				s = (l + r) / 2;
			end
			if (!found || d > best_d) begin
				found = 1'b1;
				best_d = d;
				best_s = s;
			end
			i = r + 1;
		end
		if (!found) begin
			res.seat = '0;
			res.stat = ST_FULL;
		end else begin
			seat_taken[best_s] = 1'b1;
			res.seat = best_s[SEAT_W-1:0];
			res.stat = ST_SEATED;
		end
		return res;
	endfunction

	// watch config, result and request beats
	always @(posedge clk or negedge arst_n) begin
		seat_result_t got, want;
		if (!arst_n) begin
			foreach (seat_taken[k]) seat_taken[k] = 1'b0;
			row_setting = SEAT_COUNT_RST;
			results_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) row_setting = seat_count;
			// result beat against the oldest expectation
			if (done) begin
				got.seat = chosen_seat;
				got.stat = status;
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: seat %0d status %0d", got.seat, got.stat);
				end else begin
					want = results_due.pop_front();
					if (got.seat !== want.seat || got.stat !== want.stat) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected seat %0d status %0d, got seat %0d status %0d",
								want.seat, want.stat, got.seat, got.stat);
					end
				end
			end
			// request beat
			if (start && !busy) results_due.push_back(predict_seat(mode, seat_index));
		end
		pending <= results_due.size();
		fail_count <= mismatches;
	end

endmodule

### tb/tb_farthest_gap_slot_allocator.sv
module tb_farthest_gap_slot_allocator;
	import fgsa_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              mode = MODE_OCCUPY;
	logic [SEAT_W-1:0] seat_index = '0;
	logic              done;
	logic [SEAT_W-1:0] chosen_seat;
	logic [STAT_W-1:0] status;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  seat_count = '0;
	int                fail_count;
	int                pending;
	bit                idle_on = 1'b1;

	always #5 clk = ~clk;

	farthest_gap_slot_allocator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.seat_index (seat_index),
		.done       (done),
		.chosen_seat(chosen_seat),
		.status     (status),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.seat_count (seat_count)
	);

	fgsa_result_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.seat_index (seat_index),
		.done       (done),
		.chosen_seat(chosen_seat),
		.status     (status),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.seat_count (seat_count),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// watchdog
	initial begin
		#15_000_000;
		$display("tb: failure");
		$finish;
	end

	// one request beat, with an occasional idle gap in front
	task automatic send_req(input logic m, input logic [SEAT_W-1:0] idx);
		int gap;
		if (idle_on && $urandom_range(99) < 17) begin
			start <= 1'b0;
			gap = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		seat_index <= idx;
		do @(posedge clk); while (busy);
	endtask

	// hold off until every outstanding result is back
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// seat count write beat, block idle
	task automatic write_count(input logic [CFG_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		seat_count <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [CFG_W-1:0] cnt;
		int rows, occ_pct, items;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// full row from reset: ends, inner middles, refused releases
		send_req(MODE_OCCUPY, 8'hFF);
		send_req(MODE_OCCUPY, 8'h00);
		send_req(MODE_OCCUPY, 8'h5A);
		send_req(MODE_OCCUPY, 8'hA5);
		send_req(MODE_RELEASE, 8'd255);
		send_req(MODE_RELEASE, 8'd255);
		send_req(MODE_RELEASE, 8'd200);
		send_req(MODE_OCCUPY, 8'h00);
		send_req(MODE_RELEASE, 8'd0);

		// one slot: seat, full, release beyond the row with a kept flag
		write_count(9'd1);
		send_req(MODE_OCCUPY, 8'hFF);
		send_req(MODE_OCCUPY, 8'h00);
		send_req(MODE_RELEASE, 8'd191);
		send_req(MODE_RELEASE, 8'd0);

		// zero count acts as one slot
		write_count(9'd0);
		send_req(MODE_OCCUPY, 8'h00);
		send_req(MODE_OCCUPY, 8'h00);
		send_req(MODE_RELEASE, 8'd0);

		// count above the row saturates, old flags come back into view
		write_count(9'd511);
		send_req(MODE_RELEASE, 8'd191);
		send_req(MODE_OCCUPY, 8'h00);
		send_req(MODE_RELEASE, 8'd255);

		// two slots
		write_count(9'd2);
		send_req(MODE_OCCUPY, 8'h00);
		send_req(MODE_OCCUPY, 8'h00);
		send_req(MODE_OCCUPY, 8'h00);
		send_req(MODE_RELEASE, 8'd1);
		send_req(MODE_OCCUPY, 8'h00);

		write_count(9'd256);

		// random phases, mostly short rows so they fill and drain
		for (int phase = 0; phase < 14; phase++) begin
			if ($urandom_range(5) == 0) cnt = CFG_W'($urandom_range(25, 511));
			else cnt = CFG_W'($urandom_range(0, 24));
			rows = (cnt == 0) ? 1 : (int'(cnt) > MAX_SEATS_DEF) ? MAX_SEATS_DEF : int'(cnt);
			occ_pct = $urandom_range(40, 75);
			items = $urandom_range(70, 94);
			idle_on = (phase != 3);
			write_count(cnt);
			repeat (items) begin
				if ($urandom_range(99) < occ_pct)
					send_req(MODE_OCCUPY, SEAT_W'($urandom_range(255)));
				else if ($urandom_range(99) < 85)
					send_req(MODE_RELEASE, SEAT_W'($urandom_range(rows - 1)));
				else
					send_req(MODE_RELEASE, SEAT_W'($urandom_range(255)));
				if ($urandom_range(59) == 0) settle();
			end
		end
		idle_on = 1'b1;

		settle();
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### sim.f
sv/fgsa_pkg.sv
sv/fgsa_map_ram.sv
sv/fgsa_run_tracker.sv
sv/fgsa_gap_eval.sv
sv/farthest_gap_slot_allocator.sv
tb/fgsa_result_checker.sv
tb/tb_farthest_gap_slot_allocator.sv
